// ===== hdl/hxi_pkg.sv =====
// ----------------------------------------------------------------------------
// Hex text parser package
// Widths, character codes, status codes, parser phases and the result record
// shared by the hex text parser modules and interfaces.
// ----------------------------------------------------------------------------
package hxi_pkg;

   localparam int CHAR_W   = 8;
   localparam int VALUE_W  = 64;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 16;
   localparam int COUNT_W  = 5;
   localparam int DIGIT_W  = 4;

   // Significant digit count saturates one past the number of digits that fit.
   localparam logic [COUNT_W-1:0] DIGITS_FIT = COUNT_W'(VALUE_W / DIGIT_W);
   localparam logic [COUNT_W-1:0] COUNT_SAT  = COUNT_W'(VALUE_W / DIGIT_W + 1);

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
   localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;
   localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;

   // Letters a-f and A-F carry their value as the low nibble plus this offset.
   localparam logic [DIGIT_W-1:0] LETTER_OFS = 4'd9;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_DIGITS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MIXED     = 2'd2;

   typedef enum logic [4:0] {
      PH_DONE   = 5'b00001,
      PH_SPACES = 5'b00010,
      PH_ZERO   = 5'b00100,
      PH_PREFIX = 5'b01000,
      PH_DIGITS = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  parsed_value;
      logic [STATUS_W-1:0] status;
      logic                overflow;
      logic [POS_W-1:0]    stop_position;
   } result_type;

endpackage

// ===== hdl/hxi_req_if.sv =====
// ----------------------------------------------------------------------------
// Hex text parser character channel
// Valid/ready channel that carries one character byte and a start marker.
// ----------------------------------------------------------------------------
interface hxi_req_if import hxi_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              first_char;

   modport source (output valid, output char_code, output first_char, input ready);
   modport sink   (input valid, input char_code, input first_char, output ready);

endinterface

// ===== hdl/hxi_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Hex text parser result channel
// Valid/ready channel that carries one parsed number with status and position.
// ----------------------------------------------------------------------------
interface hxi_rsp_if import hxi_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  parsed_value;
   logic [STATUS_W-1:0] status;
   logic                overflow;
   logic [POS_W-1:0]    stop_position;

   modport source (output valid, output parsed_value, output status, output overflow,
                   output stop_position, input ready);
   modport sink   (input valid, input parsed_value, input status, input overflow,
                   input stop_position, output ready);

endinterface

// ===== hdl/hxi_parse.sv =====
// ----------------------------------------------------------------------------
// Hex text parser core
// Holds the parse state and steps it by one character per processed item,
// raising a result when the number ends.
// ----------------------------------------------------------------------------
module hxi_parse import hxi_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] char_code,
   input  logic              first_char,
   output logic              res_valid,
   output result_type        res
);

   phase_type          phase_ff, phase_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic               seen_lower_ff, seen_lower_in;
   logic               seen_upper_ff, seen_upper_in;
   logic [COUNT_W-1:0] digit_count_ff, digit_count_in;
   logic [POS_W-1:0]   char_pos_ff, char_pos_in;

   phase_type          cur_phase;
   phase_type          work_phase;
   logic [VALUE_W-1:0] cur_acc;
   logic               cur_lower;
   logic               cur_upper;
   logic [COUNT_W-1:0] cur_count;
   logic [POS_W-1:0]   cur_pos;
   logic               classify_now;
   logic               is_dec;
   logic               is_lower;
   logic               is_upper;
   logic [DIGIT_W-1:0] digit_val;

   assign is_dec   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
   assign is_lower = (char_code >= CH_LO_A) && (char_code <= CH_LO_F);
   assign is_upper = (char_code >= CH_UP_A) && (char_code <= CH_UP_F);
   assign digit_val = is_dec ? char_code[DIGIT_W-1:0]
                             : char_code[DIGIT_W-1:0] + LETTER_OFS;

   always_comb begin
      // A start marker restarts the parse and the same character is offset 0.
      if (first_char) begin
         cur_phase = PH_SPACES;
         cur_acc   = '0;
         cur_lower = 1'b0;
         cur_upper = 1'b0;
         cur_count = '0;
         cur_pos   = '0;
      end else begin
         cur_phase = phase_ff;
         cur_acc   = acc_ff;
         cur_lower = seen_lower_ff;
         cur_upper = seen_upper_ff;
         cur_count = digit_count_ff;
         cur_pos   = char_pos_ff;
      end

      phase_in       = phase_ff;
      acc_in         = acc_ff;
      seen_lower_in  = seen_lower_ff;
      seen_upper_in  = seen_upper_ff;
      digit_count_in = digit_count_ff;
      char_pos_in    = char_pos_ff;
      res_valid      = 1'b0;
      res            = '{parsed_value: cur_acc, status: ST_OK,
                         overflow: (cur_count > DIGITS_FIT), stop_position: cur_pos};
      work_phase     = cur_phase;
      classify_now   = 1'b0;

      if (step && (cur_phase != PH_DONE)) begin
         phase_in       = cur_phase;
         acc_in         = cur_acc;
         seen_lower_in  = cur_lower;
         seen_upper_in  = cur_upper;
         digit_count_in = cur_count;
         char_pos_in    = (cur_pos != '1) ? cur_pos + 1'b1 : cur_pos;
         classify_now   = 1'b1;

         unique case (cur_phase)
            PH_SPACES: begin
               if (char_code == CH_SPACE) begin
                  classify_now = 1'b0;
               end else if (char_code == CH_ZERO) begin
                  phase_in     = PH_ZERO;
                  classify_now = 1'b0;
               end else begin
                  work_phase = PH_PREFIX;
               end
            end
            PH_ZERO: begin
               if (char_code == CH_LO_X) begin
                  phase_in     = PH_PREFIX;
                  classify_now = 1'b0;
               end else begin
                  work_phase = PH_DIGITS;
               end
            end
            default: work_phase = cur_phase;
         endcase

         if (classify_now) begin
            if (!is_dec && !is_lower && !is_upper) begin
               res_valid = 1'b1;
               phase_in  = PH_DONE;
               if (work_phase == PH_PREFIX) begin
                  res = '{parsed_value: '1, status: ST_NO_DIGITS,
                          overflow: 1'b0, stop_position: '0};
               end
            end else if ((is_lower && cur_upper) || (is_upper && cur_lower)) begin
               res_valid = 1'b1;
               phase_in  = PH_DONE;
               res       = '{parsed_value: '1, status: ST_MIXED,
                             overflow: 1'b0, stop_position: '0};
            end else begin
               seen_lower_in = cur_lower | is_lower;
               seen_upper_in = cur_upper | is_upper;
               acc_in        = {cur_acc[VALUE_W-DIGIT_W-1:0], digit_val};
               // Leading zeros are not significant digits.
               if (((cur_count != '0) || (digit_val != '0)) && (cur_count < COUNT_SAT)) begin
                  digit_count_in = cur_count + 1'b1;
               end
               phase_in = PH_DIGITS;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_DONE;
         acc_ff         <= '0;
         seen_lower_ff  <= 1'b0;
         seen_upper_ff  <= 1'b0;
         digit_count_ff <= '0;
         char_pos_ff    <= '0;
      end else begin
         phase_ff       <= phase_in;
         acc_ff         <= acc_in;
         seen_lower_ff  <= seen_lower_in;
         seen_upper_ff  <= seen_upper_in;
         digit_count_ff <= digit_count_in;
         char_pos_ff    <= char_pos_in;
      end
   end

   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= COUNT_SAT)
      else $error("significant digit count ran past its saturation value");

   a_done_on_result: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (phase_ff == PH_DONE) || $past(first_char) || first_char
                    || (phase_ff == PH_SPACES))
      else $error("parser did not stop after a result");

endmodule

// ===== hdl/hex_text_to_integer_unit.sv =====
// ----------------------------------------------------------------------------
// Hex text to integer unit
// Streams characters in and emits one parsed hexadecimal number per string.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload                                        Transfer
//   req_if   in         char_code[7:0], first_char                     valid & ready
//   rsp_if   out        parsed_value[63:0], status[1:0], overflow,     valid & ready
//                       stop_position[15:0]
//
// One character per cycle is sustained while no result is stalled; a character is
// held in the input register and its result, if any, is captured in the output
// register when the parse steps. The one-character step of the parse state is the
// single path between them. A waiting result stalls the input register and the
// parse state, though an empty input register still fills; the input side keeps
// taking characters while the output is free or being transferred.
// Reset is synchronous and leaves the parser waiting for a start marker.
// ----------------------------------------------------------------------------
module hex_text_to_integer_unit import hxi_pkg::*; (
   input logic       clock,
   input logic       reset,
   hxi_req_if.sink   req_if,
   hxi_rsp_if.source rsp_if
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_first_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_data_ff;

   logic       advance;
   logic       item_step;
   logic       req_xfer;
   logic       parse_valid;
   result_type parse_res;

   assign advance   = !out_valid_ff || rsp_if.ready;
   assign item_step = in_valid_ff && advance;
   assign req_if.ready = !in_valid_ff || advance;
   assign req_xfer  = req_if.valid && req_if.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (item_step ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? parse_valid : out_valid_ff;

   hxi_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (item_step),
      .char_code  (in_char_ff),
      .first_char (in_first_ff),
      .res_valid  (parse_valid),
      .res        (parse_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_char_ff  <= req_if.char_code;
         in_first_ff <= req_if.first_char;
      end
      if (advance && parse_valid) begin
         out_data_ff <= parse_res;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.parsed_value  = out_data_ff.parsed_value;
   assign rsp_if.status        = out_data_ff.status;
   assign rsp_if.overflow      = out_data_ff.overflow;
   assign rsp_if.stop_position = out_data_ff.stop_position;

   a_result_from_item: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(item_step))
      else $error("result appeared without a processed character");

   a_no_step_on_stall: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_if.ready) |-> !item_step)
      else $error("character processed while a result was stalled");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_data_ff.status != ST_OK)) |->
         ((out_data_ff.parsed_value == '1) && !out_data_ff.overflow
          && (out_data_ff.stop_position == '0)))
      else $error("error result carries a value or position");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_data_ff.status == ST_OK) || (out_data_ff.status == ST_NO_DIGITS)
                        || (out_data_ff.status == ST_MIXED)))
      else $error("result status is not a defined code");

endmodule
